// ===== hw/rtl/bra_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bra_pkg
// Types and constants shared by the boot region allocator modules.
// ----------------------------------------------------------------------------
package bra_pkg;
    localparam int PAGE_BYTES   = 4096;
    localparam int FRAG_SLOTS   = 16;
    localparam int ADDR_BITS    = 48;
    localparam int HEADER_BYTES = 16;
    localparam int WORD_BYTES   = 8;
    localparam int REG_BITS     = 48;
    localparam int PAGE_LOG     = $clog2(PAGE_BYTES);
    localparam int WORD_LOG     = $clog2(WORD_BYTES);
    localparam int IDX_BITS     = (FRAG_SLOTS > 1) ? $clog2(FRAG_SLOTS) : 1;
    localparam int CNT_BITS     = $clog2(FRAG_SLOTS + 1);
    localparam int PADDR_BITS   = 5;

    typedef enum logic [1:0] {
        FN_PAGES   = 2'd0,
        FN_BYTES   = 2'd1,
        FN_RECLAIM = 2'd2,
        FN_QUERY   = 2'd3
    } t_func;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_LOCKED  = 3'd1;
    localparam logic [2:0] ST_EXHAUST = 3'd2;
    localparam logic [2:0] ST_NULL    = 3'd3;
    localparam logic [2:0] ST_OVERRUN = 3'd4;

    localparam logic [2:0] REG_START = 3'd0;
    localparam logic [2:0] REG_BYTES = 3'd1;
    localparam logic [2:0] REG_GBASE = 3'd2;
    localparam logic [2:0] REG_GEND  = 3'd3;

    // Controller to datapath commands.
    typedef struct packed {
        logic                load;     // capture the item
        logic                pages;    // do a page request
        logic                bump;     // byte request bumps the cursor
        logic                rd;       // read fragment at idx
        logic [IDX_BITS-1:0] idx;
        logic                take;     // hold the fragment that fits
        logic                hit;      // remove fragment idx, push remainder
        logic                shift;    // move entry idx-1 into idx-2
        logic                clear;    // empty the table, lock
        logic                emit_gap;
        logic                emit_frag;
        logic                emit_misc; // single answer with given status
        logic [2:0]          misc_st;
        logic                last;
    } t_cmd;

    typedef struct packed {
        logic                fits;     // fragment read last cycle is big enough
        logic                locked;
        logic [CNT_BITS-1:0] count;
        logic                pg_zero;
        logic                pg_over;
        logic                gap_any;
    } t_stat;
endpackage
`default_nettype wire

// ===== hw/rtl/bra_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bra_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module bra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/bra_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bra_ctrl
// Sequencer: decodes an item, walks the fragment table and orders results.
// ----------------------------------------------------------------------------
module bra_ctrl import bra_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic [1:0] i_func,
    input  wire t_stat      i_stat,
    output t_cmd            o_cmd,
    output logic            o_busy
);
    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_SRD, S_SCHK, S_SHIFT, S_PUSH, S_GAP, S_FRD, S_FEMIT
    } t_state;

    t_state              r_state;
    logic [1:0]          r_func;
    logic [CNT_BITS-1:0] r_i;     // walk position plus one
    logic [CNT_BITS-1:0] r_hit;

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        o_cmd = '0;
        o_cmd.idx = IDX_BITS'(r_i - CNT_BITS'(1));
        unique case (r_state)
            S_IDLE: o_cmd.load = i_start;
            S_DEC: begin
                if (r_func == FN_QUERY) begin
                    o_cmd.emit_misc = 1'b1; o_cmd.misc_st = ST_OK; o_cmd.last = 1'b1;
                end else if (i_stat.locked) begin
                    o_cmd.emit_misc = 1'b1; o_cmd.misc_st = ST_LOCKED; o_cmd.last = 1'b1;
                end else if (r_func == FN_PAGES) begin
                    o_cmd.last = 1'b1;
                    if (i_stat.pg_zero) begin
                        o_cmd.emit_misc = 1'b1; o_cmd.misc_st = ST_NULL;
                    end else if (i_stat.pg_over) begin
                        o_cmd.emit_misc = 1'b1; o_cmd.misc_st = ST_EXHAUST;
                    end else begin
                        o_cmd.pages = 1'b1;
                    end
                end else if (r_func == FN_BYTES) begin
                    if (i_stat.count == '0) begin
                        o_cmd.bump = 1'b1; o_cmd.last = 1'b1;
                    end
                end else if (!i_stat.gap_any && i_stat.count == '0) begin
                    o_cmd.emit_misc = 1'b1; o_cmd.misc_st = ST_OK; o_cmd.last = 1'b1;
                    o_cmd.clear = 1'b1;
                end
            end
            S_SRD: o_cmd.rd = 1'b1;
            S_SCHK: begin
                o_cmd.take = i_stat.fits;
                if (!i_stat.fits && r_i == CNT_BITS'(1)) begin
                    o_cmd.bump = 1'b1; o_cmd.last = 1'b1;
                end
            end
            S_SHIFT: begin
                o_cmd.idx = IDX_BITS'(r_i);
                o_cmd.rd = 1'b1;
                o_cmd.shift = (r_i != r_hit);
            end
            S_PUSH: begin
                o_cmd.hit = 1'b1; o_cmd.last = 1'b1;
            end
            S_GAP: begin
                o_cmd.emit_gap = 1'b1; o_cmd.last = (i_stat.count == '0);
                o_cmd.clear = (i_stat.count == '0);
            end
            S_FRD: o_cmd.rd = 1'b1;
            S_FEMIT: begin
                o_cmd.emit_frag = 1'b1;
                o_cmd.last = (r_i == CNT_BITS'(1));
                o_cmd.clear = (r_i == CNT_BITS'(1));
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_func  <= '0;
            r_i     <= '0;
            r_hit   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_start) begin
                    r_func <= i_func; r_state <= S_DEC;
                end
                S_DEC: begin
                    r_i <= i_stat.count;
                    if (r_func == FN_QUERY || i_stat.locked || r_func == FN_PAGES)
                        r_state <= S_IDLE;
                    else if (r_func == FN_BYTES)
                        r_state <= (i_stat.count == '0) ? S_IDLE : S_SRD;
                    else if (i_stat.gap_any) r_state <= S_GAP;
                    else r_state <= (i_stat.count == '0) ? S_IDLE : S_FRD;
                end
                S_SRD: r_state <= S_SCHK;
                S_SCHK: begin
                    if (i_stat.fits) begin
                        // Close the hole by pulling the newer entries down.
                        r_hit <= r_i;
                        r_state <= (r_i == i_stat.count) ? S_PUSH : S_SHIFT;
                    end else if (r_i == CNT_BITS'(1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_i <= r_i - CNT_BITS'(1); r_state <= S_SRD;
                    end
                end
                S_SHIFT: begin
                    // The entry read on the previous step is written one slot down.
                    if (r_i == i_stat.count) r_state <= S_PUSH;
                    r_i <= r_i + CNT_BITS'(1);
                end
                S_PUSH: r_state <= S_IDLE;
                S_GAP: r_state <= (i_stat.count == '0) ? S_IDLE : S_FRD;
                S_FRD: r_state <= S_FEMIT;
                S_FEMIT: begin
                    if (r_i == CNT_BITS'(1)) r_state <= S_IDLE;
                    else begin
                        r_i <= r_i - CNT_BITS'(1); r_state <= S_FRD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/bra_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bra_dpath
// Cursor, byte budget, lock, fragment table and result registers.
// ----------------------------------------------------------------------------
module bra_dpath import bra_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [31:0]           i_amount,
    input  wire t_cmd                  i_cmd,
    input  wire logic                  i_cfg_we,
    input  wire logic [2:0]            i_cfg_sel,
    input  wire logic [REG_BITS-1:0]   i_cfg_data,
    input  wire logic [2:0]            i_rd_sel,
    output logic [REG_BITS-1:0]        o_rd_data,
    output t_stat                      o_stat,
    output logic                       o_valid,
    output logic [2:0]                 o_status,
    output logic [REG_BITS-1:0]        o_address,
    output logic [REG_BITS-1:0]        o_length,
    output logic                       o_kind,
    output logic                       o_locked_now,
    output logic                       o_last
);
    localparam int FW = 2 * ADDR_BITS;

    logic [REG_BITS-1:0]  r_rstart, r_rbytes, r_gbase, r_gend;
    logic [ADDR_BITS-1:0] r_cursor, r_left, r_req, r_preq;
    logic                 r_locked, r_hi;
    logic [ADDR_BITS-1:0] r_hbase, r_hleft;
    logic [CNT_BITS-1:0]  r_count;
    logic [ADDR_BITS-1:0] f_base, f_len;
    logic [FW-1:0]        w_rdata;
    logic                 w_we;
    logic [IDX_BITS-1:0]  w_waddr;
    logic [FW-1:0]        w_wdata;
    logic [ADDR_BITS-1:0] w_gap, w_alnc, w_left;
    logic                 w_mis, w_full;

    assign f_base = w_rdata[FW-1:ADDR_BITS];
    assign f_len  = w_rdata[ADDR_BITS-1:0];

    assign w_mis  = (r_cursor[PAGE_LOG-1:0] != '0);
    assign w_gap  = ADDR_BITS'(PAGE_BYTES) - {{(ADDR_BITS-PAGE_LOG){1'b0}},
                                               r_cursor[PAGE_LOG-1:0]};
    assign w_alnc = w_mis ? r_cursor + w_gap : r_cursor;
    assign w_full = (r_count >= CNT_BITS'(FRAG_SLOTS));
    assign w_left = f_len - r_req;

    always_comb begin
        w_we = 1'b0; w_waddr = r_count[IDX_BITS-1:0]; w_wdata = {r_cursor, w_gap};
        if (i_cmd.pages && w_mis && !w_full) w_we = 1'b1;
        if (i_cmd.shift) begin
            w_we = 1'b1; w_waddr = IDX_BITS'(i_cmd.idx - IDX_BITS'(2)); w_wdata = w_rdata;
        end
        if (i_cmd.hit && r_hi) begin
            w_we = 1'b1; w_waddr = IDX_BITS'(r_count - CNT_BITS'(1));
            w_wdata = {r_hbase + r_req, r_hleft};
        end
    end

    bra_ram #(.WIDTH(FW), .DEPTH(1 << IDX_BITS)) u_frag (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(i_cmd.idx), .o_rdata(w_rdata)
    );

    assign o_stat.fits    = (f_len >= r_req);
    assign o_stat.locked  = r_locked;
    assign o_stat.count   = r_count;
    assign o_stat.pg_zero = (r_preq == '0);
    assign o_stat.pg_over = (r_preq > r_left);
    assign o_stat.gap_any = (r_gend > r_gbase);

    always_comb begin
        case (i_rd_sel)
            REG_START: o_rd_data = r_rstart;
            REG_BYTES: o_rd_data = r_rbytes;
            REG_GBASE: o_rd_data = r_gbase;
            REG_GEND:  o_rd_data = r_gend;
            default:   o_rd_data = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rstart <= '0; r_rbytes <= '0; r_gbase <= '0; r_gend <= '0;
            r_cursor <= '0; r_left <= '0; r_locked <= 1'b0; r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_sel)
                    REG_START: begin
                        r_rstart <= i_cfg_data; r_cursor <= ADDR_BITS'(i_cfg_data);
                    end
                    REG_BYTES: begin
                        r_rbytes <= i_cfg_data; r_left <= ADDR_BITS'(i_cfg_data);
                    end
                    REG_GBASE: r_gbase <= i_cfg_data;
                    REG_GEND:  r_gend <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                // Words rounded up; the carry out of 32 bits is kept.
                r_req  <= ADDR_BITS'((({1'b0, i_amount} + 33'(WORD_BYTES - 1))
                                     >> WORD_LOG) << WORD_LOG);
                r_preq <= ADDR_BITS'({i_amount, {PAGE_LOG{1'b0}}});
            end
            if (i_cmd.take) begin
                r_hbase <= f_base;
                r_hleft <= w_left;
                r_hi    <= (w_left >= ADDR_BITS'(HEADER_BYTES));
            end
            if (i_cmd.pages) begin
                r_cursor <= w_alnc + r_preq;
                r_left   <= r_left - r_preq;
                if (w_mis && !w_full) r_count <= r_count + CNT_BITS'(1);
            end
            if (i_cmd.bump) begin
                r_cursor <= r_cursor + r_req;
                r_left   <= (r_req > r_left) ? '0 : r_left - r_req;
            end
            if (i_cmd.hit && !r_hi) r_count <= r_count - CNT_BITS'(1);
            if (i_cmd.clear) begin
                r_count <= '0; r_locked <= 1'b1;
            end
            if (i_cmd.pages || i_cmd.bump || i_cmd.hit || i_cmd.emit_misc
                || i_cmd.emit_gap || i_cmd.emit_frag) begin
                o_valid <= 1'b1;
            end
            o_last <= i_cmd.last;
            o_locked_now <= r_locked || i_cmd.clear || i_cmd.emit_gap || i_cmd.emit_frag;
            o_status <= ST_OK; o_address <= '0; o_length <= '0; o_kind <= 1'b0;
            if (i_cmd.pages) begin
                o_status  <= (w_mis && w_full) ? ST_OVERRUN : ST_OK;
                o_address <= REG_BITS'(w_alnc);
            end
            if (i_cmd.bump) begin
                o_status  <= (r_req > r_left) ? ST_OVERRUN : ST_OK;
                o_address <= REG_BITS'(r_cursor);
            end
            if (i_cmd.hit) o_address <= REG_BITS'(r_hbase);
            if (i_cmd.emit_misc) o_status <= i_cmd.misc_st;
            if (i_cmd.emit_gap) begin
                o_address <= r_gbase; o_length <= r_gend - r_gbase; o_kind <= 1'b1;
            end
            if (i_cmd.emit_frag) begin
                o_address <= REG_BITS'(f_base); o_length <= REG_BITS'(f_len);
                o_kind <= 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/boot_region_allocator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// boot_region_allocator
// Bump allocator with a newest-first fragment table and reclaim.
//
// channel   signals                          handshake
// item in   i_func, i_amount                 start && !busy
// result    o_status .. o_last               o_valid, one cycle
// config    psel/penable/pwrite/paddr/pwdata APB, pready tied high
//
// Query, locked and page items: the result is registered from the decode state,
// and the next item can be accepted in the cycle in which it is on the ports.
// Byte items read and check fragments newest first; a hit then moves each newer
// entry down one slot and pushes back a remainder of at least HEADER_BYTES.
// Reclaim gives the spare gap, if any, after decode, then each fragment newest first.
// Reset is synchronous; the table has no clearing pass, only a count.
// Results cannot be stalled.
// ----------------------------------------------------------------------------
module boot_region_allocator import bra_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [1:0]            i_func,
    input  wire logic [31:0]           i_amount,
    output logic                       o_valid,
    output logic [2:0]                 o_status,
    output logic [REG_BITS-1:0]        o_address,
    output logic [REG_BITS-1:0]        o_length,
    output logic                       o_kind,
    output logic                       o_locked_now,
    output logic                       o_last,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_BITS-1:0] paddr,
    input  wire logic [63:0]           pwdata,
    output logic [63:0]                prdata,
    output logic                       pready
);
    t_cmd                w_cmd;
    t_stat               w_stat;
    logic [REG_BITS-1:0] w_rd;

    assign pready = 1'b1;
    assign prdata = {{(64-REG_BITS){1'b0}}, w_rd};

    bra_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_func(i_func),
        .i_stat(w_stat), .o_cmd(w_cmd), .o_busy(busy)
    );

    bra_dpath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_amount(i_amount), .i_cmd(w_cmd),
        .i_cfg_we(psel && penable && pwrite),
        .i_cfg_sel({1'b0, paddr[4:3]}), .i_cfg_data(pwdata[REG_BITS-1:0]),
        .i_rd_sel({1'b0, paddr[4:3]}), .o_rd_data(w_rd), .o_stat(w_stat),
        .o_valid(o_valid), .o_status(o_status), .o_address(o_address),
        .o_length(o_length), .o_kind(o_kind), .o_locked_now(o_locked_now),
        .o_last(o_last)
    );
endmodule
`default_nettype wire

// ===== hw/rtl/bra_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bra_checker
// Port-level checks on the allocator.
// ----------------------------------------------------------------------------
module bra_checker import bra_pkg::*; (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_valid,
    input wire logic       o_kind,
    input wire logic       o_locked_now,
    input wire logic       o_last,
    input wire logic [2:0] o_status
);
    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("item accepted but not busy");
    a_kind_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind |-> o_locked_now) else $error("reclaim without lock");
    a_kind_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind |-> o_status == ST_OK) else $error("reclaim bad status");
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> busy) else $error("idle before last result");
endmodule

bind boot_region_allocator bra_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_kind(o_kind), .o_locked_now(o_locked_now),
    .o_last(o_last), .o_status(o_status)
);
`default_nettype wire

// ===== tb/sv/boot_region_allocator_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// boot_region_allocator_checker
// Watches the item, result and register channels of the allocator, keeps its
// own copy of the cursor, byte budget, lock and fragment table, and compares
// every result field by field against the oldest predicted answer.
// ----------------------------------------------------------------------------
module boot_region_allocator_checker import bra_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic                  i_busy,
    input  wire logic [1:0]            i_func,
    input  wire logic [31:0]           i_amount,
    input  wire logic                  i_valid,
    input  wire logic [2:0]            i_status,
    input  wire logic [REG_BITS-1:0]   i_address,
    input  wire logic [REG_BITS-1:0]   i_length,
    input  wire logic                  i_kind,
    input  wire logic                  i_locked_now,
    input  wire logic                  i_last,
    input  wire logic                  i_psel,
    input  wire logic                  i_penable,
    input  wire logic                  i_pwrite,
    input  wire logic                  i_pready,
    input  wire logic [PADDR_BITS-1:0] i_paddr,
    input  wire logic [63:0]           i_pwdata,
    output int                         o_errors,
    output int                         o_pending
);
    typedef struct {
        logic [2:0]          status;
        logic [REG_BITS-1:0] address;
        logic [REG_BITS-1:0] length;
        logic                kind;
        logic                locked_now;
        logic                last;
    } t_answer;

    t_answer                answers_q[$];
    logic [REG_BITS-1:0]    cfg_gap_base, cfg_gap_end;
    logic [ADDR_BITS-1:0]   cursor, bytes_left;
    logic                   locked;
    logic [ADDR_BITS-1:0]   frag_base[FRAG_SLOTS];
    logic [ADDR_BITS-1:0]   frag_len[FRAG_SLOTS];
    int                     frag_cnt;

    assign o_pending = answers_q.size();

    task automatic add_answer(logic [2:0] st, logic [REG_BITS-1:0] addr,
                              logic [REG_BITS-1:0] len, logic kind, logic last);
        t_answer a;
        a.status = st; a.address = addr; a.length = len;
        a.kind = kind; a.locked_now = locked; a.last = last;
        answers_q.push_back(a);
    endtask

    function automatic bit frag_add(logic [ADDR_BITS-1:0] base, logic [ADDR_BITS-1:0] len);
        if (frag_cnt >= FRAG_SLOTS) return 0;
        frag_base[frag_cnt] = base;
        frag_len[frag_cnt]  = len;
        frag_cnt++;
        return 1;
    endfunction

    task automatic allocate_pages(logic [31:0] amount);
        logic [63:0]          req;
        logic [ADDR_BITS-1:0] gap;
        logic [2:0]           st;
        req = 64'(amount) * PAGE_BYTES;
        st  = ST_OK;
        if (amount == 0) begin
            add_answer(ST_NULL, '0, '0, 1'b0, 1'b1);
        end else if (req > 64'(bytes_left)) begin
            add_answer(ST_EXHAUST, '0, '0, 1'b0, 1'b1);
        end else begin
            if (cursor % PAGE_BYTES != 0) begin
                // The alignment gap goes to the table but not against the budget.
                gap = ADDR_BITS'(PAGE_BYTES) - cursor % PAGE_BYTES;
                if (!frag_add(cursor, gap)) st = ST_OVERRUN;
                cursor = cursor + gap;
            end
            add_answer(st, cursor, '0, 1'b0, 1'b1);
            bytes_left = bytes_left - ADDR_BITS'(req);
            cursor     = cursor + ADDR_BITS'(req);
        end
    endtask

    task automatic allocate_bytes(logic [31:0] amount);
        logic [63:0]          req;
        logic [ADDR_BITS-1:0] base, left;
        req = (64'(amount) + WORD_BYTES - 1) / WORD_BYTES * WORD_BYTES;
        for (int i = frag_cnt - 1; i >= 0; i--) begin
            if (64'(frag_len[i]) >= req) begin
                base = frag_base[i];
                left = frag_len[i] - ADDR_BITS'(req);
                for (int j = i; j + 1 < frag_cnt; j++) begin
                    frag_base[j] = frag_base[j+1];
                    frag_len[j]  = frag_len[j+1];
                end
                frag_cnt--;
                if (left >= HEADER_BYTES) void'(frag_add(base + ADDR_BITS'(req), left));
                add_answer(ST_OK, base, '0, 1'b0, 1'b1);
                return;
            end
        end
        if (req > 64'(bytes_left)) begin
            bytes_left = '0;
            add_answer(ST_OVERRUN, cursor, '0, 1'b0, 1'b1);
        end else begin
            bytes_left = bytes_left - ADDR_BITS'(req);
            add_answer(ST_OK, cursor, '0, 1'b0, 1'b1);
        end
        cursor = cursor + ADDR_BITS'(req);
    endtask

    task automatic reclaim_all();
        int n;
        n = 0;
        locked = 1'b1;
        if (cfg_gap_end > cfg_gap_base) begin
            add_answer(ST_OK, cfg_gap_base, cfg_gap_end - cfg_gap_base, 1'b1, frag_cnt == 0);
            n++;
        end
        for (int i = frag_cnt - 1; i >= 0; i--) begin
            add_answer(ST_OK, frag_base[i], frag_len[i], 1'b1, i == 0);
            n++;
        end
        frag_cnt = 0;
        if (n == 0) add_answer(ST_OK, '0, '0, 1'b0, 1'b1);
    endtask

    task automatic predict_item(t_func fn, logic [31:0] amount);
        if (fn == FN_QUERY) add_answer(ST_OK, '0, '0, 1'b0, 1'b1);
        else if (locked) add_answer(ST_LOCKED, '0, '0, 1'b0, 1'b1);
        else if (fn == FN_PAGES) allocate_pages(amount);
        else if (fn == FN_BYTES) allocate_bytes(amount);
        else reclaim_all();
    endtask

    task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, got_v);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_answer a;
        logic [2:0] reg_idx;
        if (!i_rst_n) begin
            answers_q.delete();
            cfg_gap_base = '0; cfg_gap_end = '0;
            cursor = '0; bytes_left = '0; locked = 1'b0; frag_cnt = 0;
            o_errors = 0;
        end else begin
            if (i_valid) begin
                if (answers_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual status %h addr %h",
                             $realtime, i_status, i_address);
                    o_errors++;
                end else begin
                    a = answers_q.pop_front();
                    compare_field("status", 64'(a.status), 64'(i_status));
                    compare_field("address", 64'(a.address), 64'(i_address));
                    compare_field("length", 64'(a.length), 64'(i_length));
                    compare_field("kind", 64'(a.kind), 64'(i_kind));
                    compare_field("locked_now", 64'(a.locked_now), 64'(i_locked_now));
                    compare_field("last", 64'(a.last), 64'(i_last));
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                reg_idx = 3'(i_paddr >> 3);
                case (reg_idx)
                    REG_START: cursor = i_pwdata[ADDR_BITS-1:0];
                    REG_BYTES: bytes_left = i_pwdata[ADDR_BITS-1:0];
                    REG_GBASE: cfg_gap_base = i_pwdata[REG_BITS-1:0];
                    REG_GEND:  cfg_gap_end = i_pwdata[REG_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) predict_item(t_func'(i_func), i_amount);
        end
    end
endmodule

// ===== tb/sv/tb_boot_region_allocator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_boot_region_allocator
// Drives directed and random page, byte, query and reclaim items into the
// allocator across several register settings, with random idle gaps, and
// reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_boot_region_allocator;
    import bra_pkg::*;

    logic                  i_clk, i_rst_n, start, busy;
    logic [1:0]            i_func;
    logic [31:0]           i_amount;
    logic                  o_valid, o_kind, o_locked_now, o_last;
    logic [2:0]            o_status;
    logic [REG_BITS-1:0]   o_address, o_length;
    logic                  psel, penable, pwrite, pready;
    logic [PADDR_BITS-1:0] paddr;
    logic [63:0]           pwdata, prdata;
    int                    n_errors, n_pending;
    bit                    allow_idle;

    boot_region_allocator u_top (.*);

    boot_region_allocator_checker u_checker (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_func, .i_amount,
        .i_valid(o_valid), .i_status(o_status), .i_address(o_address),
        .i_length(o_length), .i_kind(o_kind), .i_locked_now(o_locked_now),
        .i_last(o_last), .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite),
        .i_pready(pready), .i_paddr(paddr), .i_pwdata(pwdata),
        .o_errors(n_errors), .o_pending(n_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("boot_region_allocator test failed");
        $finish;
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = PADDR_BITS'(idx) << 3; pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    task automatic wait_drained();
        start = 1'b0;
        while (n_pending != 0 || busy) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic load_regs(logic [63:0] rs, logic [63:0] rb, logic [63:0] gb,
                             logic [63:0] ge);
        write_reg(REG_START, rs);
        write_reg(REG_BYTES, rb);
        write_reg(REG_GBASE, gb);
        write_reg(REG_GEND, ge);
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(t_func fn, logic [31:0] amount);
        bit ok;
        if (allow_idle && $urandom_range(0, 99) < 30) begin
            start = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        start = 1'b1; i_func = fn; i_amount = amount;
        forever begin
            ok = !busy;
            @(posedge i_clk);
            @(negedge i_clk);
            if (ok) break;
        end
        if (!allow_idle || $urandom_range(0, 1)) start = 1'b0;
    endtask

    task automatic send_random(bit any_func);
        int r;
        r = $urandom_range(0, 99);
        if (any_func && r >= 90) send_item(t_func'($urandom_range(0, 3)), $urandom);
        else if (r < 40) send_item(FN_BYTES, $urandom_range(0, 64));
        else if (r < 60) send_item(FN_PAGES, $urandom_range(1, 3));
        else if (r < 70) send_item(FN_BYTES, $urandom_range(0, 5000));
        else if (r < 77) send_item(FN_QUERY, $urandom);
        else if (r < 84) send_item(FN_PAGES, $urandom_range(0, 1) ? 32'd0 : $urandom);
        else if (r < 92) send_item(FN_BYTES, $urandom);
        else send_item(FN_PAGES, $urandom_range(0, 300));
    endtask

    initial begin
        i_rst_n = 1'b0; start = 1'b0; i_func = FN_QUERY; i_amount = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        allow_idle = 1'b1;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: a misaligned start so the first page request leaves a gap.
        load_regs(64'h1000_0123, 64'h10_0000, 64'h8000, 64'h9000);
        send_item(FN_QUERY, 32'hFFFF_FFFF);
        send_item(FN_BYTES, 32'd0);
        send_item(FN_PAGES, 32'd0);
        send_item(FN_PAGES, 32'hFFFF_FFFF);
        send_item(FN_PAGES, 32'd1);
        send_item(FN_BYTES, 32'd1);
        send_item(FN_BYTES, 32'd7);
        send_item(FN_BYTES, 32'd0);
        send_item(FN_BYTES, 32'd8);
        send_item(FN_BYTES, 32'd9);
        send_item(FN_BYTES, 32'd3000);
        send_item(FN_BYTES, 32'hFFFF_FFFF);
        send_item(FN_PAGES, 32'd1);
        send_item(FN_BYTES, 32'd0);
        wait_drained();

        // Near the top of the address space, full budget: wraparound.
        load_regs(64'hFFFF_FFFF_F123, 64'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF, 64'h0);
        repeat (80) send_random(1'b0);
        wait_drained();

        // No idling here, and an empty budget to start with.
        allow_idle = 1'b0;
        load_regs(64'h0, 64'h0, 64'h0, 64'h0);
        repeat (20) send_random(1'b0);
        wait_drained();
        write_reg(REG_BYTES, 64'h40_0000);
        repeat (90) send_random(1'b0);
        wait_drained();
        allow_idle = 1'b1;

        load_regs(64'h5555_5555_5557, 64'hAAAA_AAAA, 64'h1000, 64'hFFFF_FFFF_FFFF);
        repeat (90) send_random(1'b0);
        // Small byte items and single pages: a byte item that finds no fitting fragment bumps and misaligns the cursor.
        repeat (20) begin
            send_item(FN_BYTES, 32'd24);
            send_item(FN_PAGES, 32'd1);
        end
        wait_drained();

        // Reclaim, then every item but a query answers locked.
        send_item(FN_RECLAIM, 32'd0);
        send_item(FN_RECLAIM, 32'hFFFF_FFFF);
        send_item(FN_PAGES, 32'd1);
        send_item(FN_BYTES, 32'd16);
        send_item(FN_QUERY, 32'd0);
        repeat (20) send_random(1'b1);
        start = 1'b0;
        wait_drained();

        if (n_errors == 0 && n_pending == 0) begin
            $display("boot_region_allocator test passed");
        end else begin
            $display("boot_region_allocator test failed");
        end
        $finish;
    end
endmodule
